FILE: rtl/msda_pkg.sv
`timescale 1ns / 1ps
package msda_pkg;

  localparam int MAX_FRAMES  = 256;
  localparam int MAX_ATOMS   = 1024;
  localparam int MAX_ORIGINS = 16;
  localparam int MAX_TYPES   = 8;

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int ATOM_W  = $clog2(MAX_ATOMS);
  localparam int TYPE_W  = $clog2(MAX_TYPES);
  localparam int SLOT_W  = $clog2(MAX_ORIGINS);
  localparam int USE_W   = $clog2(MAX_ORIGINS + 1);
  localparam int BIN_W   = TYPE_W + FRAME_W;
  localparam int OADDR_W = SLOT_W + ATOM_W;

  localparam int POS_W  = 24;
  localparam int SUM_W  = 60;
  localparam int SQ_W   = 2 * (POS_W + 1);
  localparam int PAIR_W = 5;
  localparam int DIV_W  = 8;
  localparam int IV_W   = 8;

  localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [7:0]              frame_index;
    logic [9:0]              atom_index;
    logic [2:0]              atom_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [7:0]              lag;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  total_msd;
    logic [SUM_W-1:0]  x_msd;
    logic [SUM_W-1:0]  y_msd;
    logic [SUM_W-1:0]  z_msd;
    logic [PAIR_W-1:0] origin_pairs;
    logic              empty_bin;
    logic              overflow_seen;
  } out_t;

endpackage

FILE: rtl/mean_squared_displacement_accumulator.sv
`timescale 1ns / 1ps
// channel   ports                        direction  accepted when
// input     in_valid  in_ready  in_data  in         in_valid && in_ready
// result    out_valid out_ready out_data out        out_valid && out_ready
// config    cfg_we    cfg_wdata          in         cfg_we high
//
// an add within the current frame reads each stored origin at or before that frame,
// squares its three axis differences through one multiplier and writes the bin back
// a frame start first runs frame % interval through the serial divider and updates
// the pair counts for each stored origin at or before that frame
// a read runs its four quotients through the same divider, unless the pair count is zero
// after reset and after a clear the bins and pair counts are swept to zero, no input taken
// a finished read waits in the output register; the next word is taken meanwhile
module mean_squared_displacement_accumulator import msda_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data,
  input  logic            cfg_we,
  input  logic [IV_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_PS_RD   = 4'd3;
  localparam logic [3:0] S_PS_WR   = 4'd4;
  localparam logic [3:0] S_STORE   = 4'd5;
  localparam logic [3:0] S_AC_RD   = 4'd6;
  localparam logic [3:0] S_AC_LD   = 4'd7;
  localparam logic [3:0] S_AC_STEP = 4'd8;
  localparam logic [3:0] S_AC_WR   = 4'd9;
  localparam logic [3:0] S_RD_LD   = 4'd10;
  localparam logic [3:0] S_RD_T0   = 4'd11;
  localparam logic [3:0] S_RD_T1   = 4'd12;
  localparam logic [3:0] S_RD_GO   = 4'd13;
  localparam logic [3:0] S_RD_DIV  = 4'd14;
  localparam logic [3:0] S_RD_OUT  = 4'd15;

  logic [3:0]              state_r;
  in_t                     item_r;
  logic [IV_W-1:0]         iv_r;
  logic                    frame_open_r;
  logic [FRAME_W-1:0]      frame_now_r;
  logic                    slot_open_r;
  logic [SLOT_W-1:0]       slot_now_r;
  logic [USE_W-1:0]        in_use_r;
  logic                    ovf_r;
  logic [FRAME_W-1:0]      ofs_r [MAX_ORIGINS];
  logic [USE_W-1:0]        s_r;
  logic [BIN_W-1:0]        clr_r;
  logic                    origin_flag_r;
  logic                    found_r;
  logic [FRAME_W-1:0]      lag_r;
  logic [1:0]              k_r;
  logic [3*POS_W-1:0]      org_r;
  logic [2:0][SUM_W-1:0]   acc_r;
  logic [SUM_W-1:0]        tot_r;
  logic [SQ_W-1:0]         sq_r;
  logic [PAIR_W-1:0]       n_r;
  logic [3:0][SUM_W-1:0]   q_r;
  logic                    out_valid_r;
  out_t                    out_r;

  logic                    in_fire;
  logic                    out_load;
  logic                    frame_start;
  logic [FRAME_W-1:0]      o_sel;
  logic                    o_le;
  logic [FRAME_W-1:0]      lag_cur;
  logic                    s_live;

  logic                    p_we;
  logic [FRAME_W-1:0]      p_waddr, p_raddr;
  logic [PAIR_W-1:0]       p_wdata, p_rdata;
  logic                    b_we;
  logic [BIN_W-1:0]        b_waddr, b_raddr;
  logic [3*SUM_W-1:0]      b_wdata, b_rdata;
  logic                    o_we;
  logic [OADDR_W-1:0]      o_waddr, o_raddr;
  logic [3*POS_W-1:0]      o_wdata, o_rdata;

  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [SUM_W-1:0]        div_dividend, div_quo;
  logic [DIV_W-1:0]        div_divisor, div_rem;

  logic signed [POS_W-1:0] pos_sel, org_sel;
  logic signed [POS_W:0]   diff;
  logic signed [SQ_W-1:0]  sq_full;
  logic [SUM_W-1:0]        add_a, add_b;
  logic [SUM_W:0]          add_sum;
  logic [SUM_W-1:0]        add_sat;

  assign in_ready  = state_r == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == S_RD_OUT) && (!out_valid_r || out_ready);

  assign frame_start = !frame_open_r || (frame_now_r != in_data.frame_index);
  assign o_sel       = ofs_r[s_r[SLOT_W-1:0]];
  assign o_le        = o_sel <= item_r.frame_index;
  assign lag_cur     = item_r.frame_index - o_sel;
  assign s_live      = s_r < in_use_r;

  // pair counts per lag
  always_comb begin
    p_we    = (state_r == S_CLR) || ((state_r == S_PS_WR) && (p_rdata != PAIR_MAX));
    p_waddr = (state_r == S_CLR) ? clr_r[FRAME_W-1:0] : lag_r;
    p_wdata = (state_r == S_CLR) ? '0 : p_rdata + 1'b1;
    p_raddr = (state_r == S_IDLE) ? in_data.lag : lag_cur;
  end

  // x, y, z sums per type and lag, x in the top field
  always_comb begin
    b_we    = (state_r == S_CLR) || (state_r == S_AC_WR);
    b_waddr = (state_r == S_CLR) ? clr_r : {item_r.atom_type, lag_r};
    b_wdata = (state_r == S_CLR) ? '0 : {acc_r[0], acc_r[1], acc_r[2]};
    b_raddr = (state_r == S_IDLE) ? {in_data.atom_type, in_data.lag}
                                  : {item_r.atom_type, lag_cur};
  end

  always_comb begin
    o_we    = (state_r == S_STORE) && slot_open_r;
    o_waddr = {slot_now_r, item_r.atom_index};
    o_wdata = {item_r.pos_x, item_r.pos_y, item_r.pos_z};
    o_raddr = {s_r[SLOT_W-1:0], item_r.atom_index};
  end

  msda_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_FRAMES)) u_pair_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  msda_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_TYPES * MAX_FRAMES)) u_bin_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  msda_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_ORIGINS * MAX_ATOMS)) u_origin_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // one divider serves frame % interval and the four quotients of a read
  always_comb begin
    div_start = (in_fire && (in_data.opcode == OP_ADD) && frame_start) ||
                (state_r == S_RD_GO);
    if (state_r == S_IDLE) begin
      div_dividend = SUM_W'(in_data.frame_index);
      div_divisor  = (iv_r == '0) ? DIV_W'(1) : DIV_W'(iv_r);
    end else begin
      case (k_r)
        2'd0:    div_dividend = tot_r;
        2'd1:    div_dividend = acc_r[0];
        2'd2:    div_dividend = acc_r[1];
        default: div_dividend = acc_r[2];
      endcase
      div_divisor = DIV_W'(n_r);
    end
  end

  msda_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dividend), .divisor(div_divisor),
    .busy(div_busy), .done(div_done),
    .quotient(div_quo), .remainder(div_rem)
  );

  // shared squarer
  always_comb begin
    case (k_r)
      2'd0: begin
        pos_sel = item_r.pos_x;
        org_sel = org_r[3*POS_W-1:2*POS_W];
      end
      2'd1: begin
        pos_sel = item_r.pos_y;
        org_sel = org_r[2*POS_W-1:POS_W];
      end
      default: begin
        pos_sel = item_r.pos_z;
        org_sel = org_r[POS_W-1:0];
      end
    endcase
    diff    = (POS_W+1)'(pos_sel) - (POS_W+1)'(org_sel);
    sq_full = diff * diff;
  end

  // shared saturating adder
  always_comb begin
    add_a = tot_r;
    add_b = acc_r[2];
    case (state_r)
      S_AC_STEP: begin
        add_b = SUM_W'(sq_r);
        case (k_r)
          2'd1:    add_a = acc_r[0];
          2'd2:    add_a = acc_r[1];
          default: add_a = acc_r[2];
        endcase
      end
      S_RD_T0: begin
        add_a = acc_r[0];
        add_b = acc_r[1];
      end
      default: begin
        add_a = tot_r;
        add_b = acc_r[2];
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_sat = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      iv_r         <= IV_W'(1);
      frame_open_r <= 1'b0;
      slot_open_r  <= 1'b0;
      in_use_r     <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        iv_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_r <= in_data;
            case (in_data.opcode)
              OP_ADD: begin
                if (frame_start) begin
                  frame_open_r <= 1'b1;
                  frame_now_r  <= in_data.frame_index;
                  slot_open_r  <= 1'b0;
                  state_r      <= S_MOD;
                end else begin
                  state_r <= S_STORE;
                end
              end
              OP_READ: state_r <= S_RD_LD;
              OP_CLEAR: begin
                in_use_r     <= '0;
                ovf_r        <= 1'b0;
                frame_open_r <= 1'b0;
                slot_open_r  <= 1'b0;
                clr_r        <= '0;
                state_r      <= S_CLR;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_MOD: begin
          if (div_done) begin
            origin_flag_r <= div_rem == '0;
            found_r       <= 1'b0;
            s_r           <= '0;
            state_r       <= S_PS_RD;
          end
        end
        S_PS_RD: begin
          if (s_live) begin
            if (origin_flag_r && (o_sel == item_r.frame_index)) begin
              found_r     <= 1'b1;
              slot_open_r <= 1'b1;
              slot_now_r  <= s_r[SLOT_W-1:0];
            end
            if (o_le) begin
              lag_r   <= lag_cur;
              state_r <= S_PS_WR;
            end else begin
              s_r <= s_r + 1'b1;
            end
          end else if (origin_flag_r && !found_r) begin
            // new origin: the slot is counted on the next pass of this loop
            if (in_use_r < USE_W'(MAX_ORIGINS)) begin
              ofs_r[in_use_r[SLOT_W-1:0]] <= item_r.frame_index;
              in_use_r <= in_use_r + 1'b1;
            end else begin
              ovf_r   <= 1'b1;
              state_r <= S_STORE;
            end
          end else begin
            state_r <= S_STORE;
          end
        end
        S_PS_WR: begin
          if (p_rdata == PAIR_MAX) begin
            ovf_r <= 1'b1;
          end
          s_r     <= s_r + 1'b1;
          state_r <= S_PS_RD;
        end
        S_STORE: begin
          s_r     <= '0;
          state_r <= S_AC_RD;
        end
        S_AC_RD: begin
          if (!s_live) begin
            state_r <= S_IDLE;
          end else if (o_le) begin
            lag_r   <= lag_cur;
            state_r <= S_AC_LD;
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        S_AC_LD: begin
          org_r    <= o_rdata;
          acc_r[0] <= b_rdata[3*SUM_W-1:2*SUM_W];
          acc_r[1] <= b_rdata[2*SUM_W-1:SUM_W];
          acc_r[2] <= b_rdata[SUM_W-1:0];
          k_r      <= '0;
          state_r  <= S_AC_STEP;
        end
        S_AC_STEP: begin
          // square axis k while adding the square of axis k-1
          sq_r <= sq_full;
          if (k_r != 2'd0) begin
            acc_r[k_r - 2'd1] <= add_sat;
            if (add_sum[SUM_W]) begin
              ovf_r <= 1'b1;
            end
          end
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            state_r <= S_AC_WR;
          end
        end
        S_AC_WR: begin
          s_r     <= s_r + 1'b1;
          state_r <= S_AC_RD;
        end
        S_RD_LD: begin
          n_r      <= p_rdata;
          acc_r[0] <= b_rdata[3*SUM_W-1:2*SUM_W];
          acc_r[1] <= b_rdata[2*SUM_W-1:SUM_W];
          acc_r[2] <= b_rdata[SUM_W-1:0];
          state_r  <= S_RD_T0;
        end
        S_RD_T0: begin
          tot_r   <= add_sat;
          state_r <= S_RD_T1;
        end
        S_RD_T1: begin
          tot_r   <= add_sat;
          k_r     <= '0;
          state_r <= (n_r == '0) ? S_RD_OUT : S_RD_GO;
        end
        S_RD_GO: begin
          state_r <= S_RD_DIV;
        end
        S_RD_DIV: begin
          if (div_done) begin
            q_r[k_r] <= div_quo;
            if (k_r == 2'd3) begin
              state_r <= S_RD_OUT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RD_GO;
            end
          end
        end
        S_RD_OUT: begin
          if (out_load) begin
            out_r.total_msd     <= (n_r == '0) ? '0 : q_r[0];
            out_r.x_msd         <= (n_r == '0) ? '0 : q_r[1];
            out_r.y_msd         <= (n_r == '0) ? '0 : q_r[2];
            out_r.z_msd         <= (n_r == '0) ? '0 : q_r[3];
            out_r.origin_pairs  <= n_r;
            out_r.empty_bin     <= n_r == '0;
            out_r.overflow_seen <= ovf_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= USE_W'(MAX_ORIGINS))
    else $error("origin slots in use beyond capacity");

  a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    slot_open_r |-> (USE_W'(slot_now_r) < in_use_r))
    else $error("open origin slot not allocated");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_OUT && out_valid_r && !out_ready) |=> state_r == S_RD_OUT)
    else $error("read result left without output room");
`endif

endmodule

FILE: rtl/msda_ram.sv
`timescale 1ns / 1ps
module msda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/msda_div.sv
`timescale 1ns / 1ps
module msda_div import msda_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [SUM_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(SUM_W);
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        quo_r <= {quo_r[SUM_W-2:0], fits};
        rem_r <= fits ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = cnt_r != '0;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
